### hw/rtl/trdt_pkg.sv
// shared constants and types for the triangle raster depth test unit
// no dependencies
package trdt_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int CRD_W   = 16;
  localparam int DEPTH_W = 24;
  localparam int ID_W    = 16;
  localparam int CNT_W   = 19;
  localparam int FRM_W   = 10;
  localparam int EDGE_W  = 34;
  localparam int NUM_W   = 60;
  localparam int PIX_W   = 13;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // which fields the result register presents
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_READ = 2'd1,
    RES_FAR  = 2'd2,
    RES_DRAW = 2'd3
  } res_kind_t;

  localparam logic CFG_WIDTH_IDX  = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture triangle and set up
    logic calc_area; // area multiply stage
    logic setup_box; // compute area, bounding box and start position
    logic pix_start; // start pixel at current position
    logic div_start; // start depth divide
    logic mem_rd;    // read store at current pixel
    logic mem_wr;    // conditional write
    logic step;      // advance to next pixel
    logic clr_start; // reset clear sweep
    logic clr_step;  // write one entry of the clear sweep
    logic rd_start;  // read command lookup
  } trdt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic culled;
    logic box_empty;
    logic covered;
    logic div_done;
    logic last_pix;
    logic clr_last;
  } trdt_sts_t;

endpackage

### hw/rtl/trdt_div.sv
// restoring divider, one quotient bit per cycle
// depends on trdt_pkg
module trdt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [trdt_pkg::NUM_W-1:0]    dividend,
  input  logic [trdt_pkg::EDGE_W-1:0]   divisor,
  output logic                          done,
  output logic [trdt_pkg::NUM_W-1:0]    quotient
);
  import trdt_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   quo;
  logic [EDGE_W:0]    rem;
  logic [EDGE_W-1:0]  dvs;
  logic [CNT_BITS-1:0] cnt;
  logic               busy;
  logic [EDGE_W:0]    trial;
  logic [EDGE_W:0]    shifted;

  always_comb begin
    shifted = {rem[EDGE_W-1:0], quo[NUM_W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[EDGE_W]) begin
        rem <= trial;
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

### hw/rtl/trdt_datapath.sv
// triangle setup, edge stepping, depth interpolation and the pixel stores
// depends on trdt_pkg and trdt_div
module trdt_datapath #(
  parameter int MAX_WIDTH  = trdt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = trdt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  trdt_pkg::trdt_cmd_t           ctl,
  output trdt_pkg::trdt_sts_t           sts,
  input  logic [trdt_pkg::FRM_W-1:0]    frame_width,
  input  logic [trdt_pkg::FRM_W-1:0]    frame_height,
  input  logic signed [trdt_pkg::CRD_W-1:0] ax,
  input  logic signed [trdt_pkg::CRD_W-1:0] ay,
  input  logic [trdt_pkg::DEPTH_W-1:0]  az,
  input  logic signed [trdt_pkg::CRD_W-1:0] bx,
  input  logic signed [trdt_pkg::CRD_W-1:0] by_coord,
  input  logic [trdt_pkg::DEPTH_W-1:0]  bz,
  input  logic signed [trdt_pkg::CRD_W-1:0] cx,
  input  logic signed [trdt_pkg::CRD_W-1:0] cy,
  input  logic [trdt_pkg::DEPTH_W-1:0]  cz,
  input  logic [trdt_pkg::ID_W-1:0]     tri_id,
  output logic [trdt_pkg::DEPTH_W-1:0]  rd_depth,
  output logic [trdt_pkg::ID_W-1:0]     rd_id,
  output logic [trdt_pkg::CNT_W-1:0]    count
);
  import trdt_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = 18;

  logic [DEPTH_W-1:0] depth_mem [DEPTH];
  logic [ID_W-1:0]    id_mem    [DEPTH];

  logic signed [SW-1:0] vax, vay, vbx, vby, vcx, vcy;
  logic [DEPTH_W-1:0]   zaz, zbz, zcz;
  logic [ID_W-1:0]      tid;
  logic signed [EDGE_W-1:0] p1, p2, area;
  logic signed [EDGE_W-1:0] e0, e1, e2;
  logic signed [PIX_W:0]    x0, x1, y0, y1, xi, yj;
  logic signed [PIX_W:0]    fw_last, fh_last;
  logic [FRM_W:0]           fw, fh;
  logic [NUM_W-1:0]         m0, m1, m2;
  logic                     div_start;
  logic                     div_done;
  logic [NUM_W-1:0]         quo;
  logic [DEPTH_W-1:0]       zval, old_depth;
  logic [AW-1:0]            addr, clr_addr;
  logic                     clr_last;
  logic [AW-1:0]            rd_addr;

  function automatic logic signed [PIX_W:0] pix_floor(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v >>> 4;
    return (PIX_W+1)'(t);
  endfunction

  function automatic logic signed [SW-1:0] min3(input logic signed [SW-1:0] a,
      input logic signed [SW-1:0] b, input logic signed [SW-1:0] c);
    logic signed [SW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [SW-1:0] max3(input logic signed [SW-1:0] a,
      input logic signed [SW-1:0] b, input logic signed [SW-1:0] c);
    logic signed [SW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // edge value at pixel center (px,py) for edge u->v
  function automatic logic signed [EDGE_W-1:0] edge_at(input logic signed [SW-1:0] ux,
      input logic signed [SW-1:0] uy, input logic signed [SW-1:0] vx,
      input logic signed [SW-1:0] vy, input logic signed [PIX_W:0] i,
      input logic signed [PIX_W:0] j);
    logic signed [EDGE_W-1:0] px, py;
    px = (EDGE_W'(i) <<< 4) + EDGE_W'(8);
    py = (EDGE_W'(j) <<< 4) + EDGE_W'(8);
    return (EDGE_W'(vx) - EDGE_W'(ux)) * (py - EDGE_W'(uy))
         - (EDGE_W'(vy) - EDGE_W'(uy)) * (px - EDGE_W'(ux));
  endfunction

  assign fw = (int'(frame_width)  > MAX_WIDTH)  ? (FRM_W+1)'(MAX_WIDTH)
                                                : {1'b0, frame_width};
  assign fh = (int'(frame_height) > MAX_HEIGHT) ? (FRM_W+1)'(MAX_HEIGHT)
                                                : {1'b0, frame_height};
  assign fw_last = $signed({3'b0, fw}) - (PIX_W+1)'(1);
  assign fh_last = $signed({3'b0, fh}) - (PIX_W+1)'(1);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vax <= SW'(ax); vay <= SW'(ay);
      vbx <= SW'(bx); vby <= SW'(by_coord);
      vcx <= SW'(cx); vcy <= SW'(cy);
      zaz <= az; zbz <= bz; zcz <= cz;
      tid <= tri_id;
    end
    if (ctl.calc_area) begin
      p1 <= (EDGE_W'(vbx) - EDGE_W'(vax)) * (EDGE_W'(vcy) - EDGE_W'(vay));
      p2 <= (EDGE_W'(vby) - EDGE_W'(vay)) * (EDGE_W'(vcx) - EDGE_W'(vax));
    end
    if (ctl.setup_box) begin
      area <= p1 - p2;
      x0 <= (pix_floor(min3(vax, vbx, vcx)) < 0) ? '0 : pix_floor(min3(vax, vbx, vcx));
      y0 <= (pix_floor(min3(vay, vby, vcy)) < 0) ? '0 : pix_floor(min3(vay, vby, vcy));
      x1 <= (pix_floor(max3(vax, vbx, vcx)) > fw_last)
            ? fw_last : pix_floor(max3(vax, vbx, vcx));
      y1 <= (pix_floor(max3(vay, vby, vcy)) > fh_last)
            ? fh_last : pix_floor(max3(vay, vby, vcy));
    end
    if (ctl.pix_start) begin
      e0 <= edge_at(vbx, vby, vcx, vcy, xi, yj);
      e1 <= edge_at(vcx, vcy, vax, vay, xi, yj);
      e2 <= edge_at(vax, vay, vbx, vby, xi, yj);
    end
    if (ctl.div_start) begin
      m0 <= NUM_W'(e0) * NUM_W'(zaz);
      m1 <= NUM_W'(e1) * NUM_W'(zbz);
      m2 <= NUM_W'(e2) * NUM_W'(zcz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xi <= '0; yj <= '0; count <= '0; div_start <= 1'b0;
    end else begin
      div_start <= ctl.div_start;
      if (ctl.load) count <= '0;
      if (ctl.setup_box) begin
        xi <= (pix_floor(min3(vax, vbx, vcx)) < 0) ? '0 : pix_floor(min3(vax, vbx, vcx));
        yj <= (pix_floor(min3(vay, vby, vcy)) < 0) ? '0 : pix_floor(min3(vay, vby, vcy));
      end
      if (ctl.step) begin
        if (xi == x1) begin
          xi <= x0;
          yj <= yj + 1'b1;
        end else begin
          xi <= xi + 1'b1;
        end
      end
      if (ctl.mem_wr && (zval < old_depth) && count != CNT_MAX) count <= count + 1'b1;
    end
  end

  trdt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (m0 + m1 + m2 + NUM_W'(area >>> 1)),
    .divisor  (area),
    .done     (div_done),
    .quotient (quo)
  );

  assign zval = (quo > NUM_W'(FAR_DEPTH)) ? FAR_DEPTH : quo[DEPTH_W-1:0];

  // clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_start) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end
  assign clr_last = (clr_addr == '1);

  // read lookup: coordinates are integer pixels for a read
  always_comb begin
    rd_addr = {vay[YW-1:0], vax[XW-1:0]};
    addr    = {yj[YW-1:0], xi[XW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      depth_mem[clr_addr] <= FAR_DEPTH;
      id_mem[clr_addr]    <= '0;
    end else if (ctl.mem_wr && (zval < old_depth)) begin
      depth_mem[addr] <= zval;
      id_mem[addr]    <= tid;
    end
    if (ctl.mem_rd) old_depth <= depth_mem[addr];
    if (ctl.rd_start) begin
      rd_depth <= depth_mem[rd_addr];
      rd_id    <= id_mem[rd_addr];
    end
  end

  assign sts.culled    = (area <= 0);
  assign sts.box_empty = (x0 > x1) || (y0 > y1);
  assign sts.covered   = !e0[EDGE_W-1] && !e1[EDGE_W-1] && !e2[EDGE_W-1];
  assign sts.div_done  = div_done;
  assign sts.last_pix  = (xi == x1) && (yj == y1);
  assign sts.clr_last  = clr_last;

endmodule

### hw/rtl/trdt_ctrl.sv
// command sequencer for draw, read, clear and no-op
// depends on trdt_pkg
module trdt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  trdt_pkg::cmd_t             cmd,
  output trdt_pkg::trdt_cmd_t        ctl,
  input  trdt_pkg::trdt_sts_t        sts,
  input  logic                       rd_in_frame,
  output logic                       out_valid,
  input  logic                       out_ready,
  output trdt_pkg::res_kind_t        res_kind
);
  import trdt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_AREA, S_BOX, S_CHECK, S_PIX, S_TEST, S_MUL, S_DIV, S_RDMEM,
    S_WRITE, S_CLEAR, S_READ, S_READ2, S_OUT
  } state_t;

  state_t state;
  cmd_t   cur;

  always_comb begin
    ctl = '0;
    in_ready = (state == S_IDLE) && !out_valid;
    ctl.load      = in_valid && in_ready;
    ctl.calc_area = (state == S_AREA);
    ctl.setup_box = (state == S_BOX);
    ctl.pix_start = (state == S_PIX);
    ctl.div_start = (state == S_MUL);
    ctl.mem_rd    = (state == S_RDMEM);
    ctl.mem_wr    = (state == S_WRITE);
    ctl.step      = (state == S_WRITE) || (state == S_TEST && !sts.covered && !sts.last_pix);
    ctl.clr_start = ctl.load;
    ctl.clr_step  = (state == S_CLEAR);
    ctl.rd_start  = (state == S_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      res_kind  <= RES_NONE;
      cur       <= CMD_NOP;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          cur <= cmd;
          case (cmd)
            CMD_DRAW:  state <= S_AREA;
            CMD_READ:  state <= S_READ;
            CMD_CLEAR: state <= S_CLEAR;
            default:   state <= S_OUT;
          endcase
        end
        S_AREA:  state <= S_BOX;
        S_BOX:   state <= S_CHECK;
        S_CHECK: state <= (sts.culled || sts.box_empty) ? S_OUT : S_PIX;
        S_PIX:   state <= S_TEST;
        S_TEST: begin
          if (sts.covered) state <= S_MUL;
          else if (sts.last_pix) state <= S_OUT;
          else state <= S_PIX;
        end
        S_MUL:   state <= S_DIV;
        S_DIV:   if (sts.div_done) state <= S_RDMEM;
        S_RDMEM: state <= S_WRITE;
        S_WRITE: state <= sts.last_pix ? S_OUT : S_PIX;
        // the sweep after reset returns no result
        S_CLEAR: if (sts.clr_last) state <= (cur == CMD_CLEAR) ? S_OUT : S_IDLE;
        S_READ:  state <= S_READ2;
        S_READ2: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          res_kind  <= (cur == CMD_READ) ? (rd_in_frame ? RES_READ : RES_FAR)
                     : (cur == CMD_DRAW) ? RES_DRAW : RES_NONE;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/triangle_raster_depth_test_unit.sv
// Triangle rasterizer with z-buffer. A draw walks the clipped bounding box one
// pixel at a time: every box pixel gets an edge test and each covered pixel
// adds a 60-step serial depth divide and the store update. A clear sweeps all
// 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) store entries (262144 at defaults),
// one entry a cycle, before its result is valid. The same sweep runs after
// reset, so the store starts at far depth; no input is accepted until it ends.
// One transaction is in flight at a time: the next can be accepted the cycle
// after the result is taken.
// depends on trdt_pkg, trdt_ctrl, trdt_datapath
module triangle_raster_depth_test_unit #(
  parameter int MAX_WIDTH  = trdt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = trdt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [trdt_pkg::FRM_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          cmd,
  input  logic signed [trdt_pkg::CRD_W-1:0]   ax,
  input  logic signed [trdt_pkg::CRD_W-1:0]   ay,
  input  logic [trdt_pkg::DEPTH_W-1:0]        az,
  input  logic signed [trdt_pkg::CRD_W-1:0]   bx,
  input  logic signed [trdt_pkg::CRD_W-1:0]   by_coord,
  input  logic [trdt_pkg::DEPTH_W-1:0]        bz,
  input  logic signed [trdt_pkg::CRD_W-1:0]   cx,
  input  logic signed [trdt_pkg::CRD_W-1:0]   cy,
  input  logic [trdt_pkg::DEPTH_W-1:0]        cz,
  input  logic [trdt_pkg::ID_W-1:0]           tri_id,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [trdt_pkg::DEPTH_W-1:0]        depth_out,
  output logic [trdt_pkg::ID_W-1:0]           id_out,
  output logic [trdt_pkg::CNT_W-1:0]          pixels_written,
  output logic                                culled
);
  import trdt_pkg::*;

  logic [FRM_W-1:0] frame_width, frame_height;
  trdt_cmd_t ctl;
  trdt_sts_t sts;
  logic [DEPTH_W-1:0] rd_depth;
  logic [ID_W-1:0]    rd_id;
  logic [CNT_W-1:0]   count;
  res_kind_t          res_kind;
  logic               rd_in_frame;
  logic [FRM_W:0]     fw, fh;
  logic signed [CRD_W-1:0] rax, ray;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRM_W'(512);
      frame_height <= FRM_W'(512);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH_IDX) frame_width <= cfg_data;
      else frame_height <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rax <= ax;
      ray <= ay;
    end
  end

  assign fw = (int'(frame_width)  > MAX_WIDTH)  ? (FRM_W+1)'(MAX_WIDTH)
                                                : {1'b0, frame_width};
  assign fh = (int'(frame_height) > MAX_HEIGHT) ? (FRM_W+1)'(MAX_HEIGHT)
                                                : {1'b0, frame_height};
  assign rd_in_frame = !rax[CRD_W-1] && !ray[CRD_W-1]
                       && ($signed({6'b0, fw}) > rax) && ($signed({6'b0, fh}) > ray);

  trdt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd_t'(cmd)),
    .ctl         (ctl),
    .sts         (sts),
    .rd_in_frame (rd_in_frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res_kind    (res_kind)
  );

  trdt_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .ax           (ax),
    .ay           (ay),
    .az           (az),
    .bx           (bx),
    .by_coord     (by_coord),
    .bz           (bz),
    .cx           (cx),
    .cy           (cy),
    .cz           (cz),
    .tri_id       (tri_id),
    .rd_depth     (rd_depth),
    .rd_id        (rd_id),
    .count        (count)
  );

  always_comb begin
    depth_out      = '0;
    id_out         = '0;
    pixels_written = '0;
    culled         = 1'b0;
    case (res_kind)
      RES_READ: begin
        depth_out = rd_depth;
        id_out    = rd_id;
      end
      RES_FAR: depth_out = FAR_DEPTH;
      RES_DRAW: begin
        culled         = sts.culled;
        pixels_written = sts.culled ? '0 : count;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/trdt_checker.sv
// port-level checks for the triangle raster depth test unit
// no package dependencies; bound to triangle_raster_depth_test_unit
module trdt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [18:0] pixels_written,
  input logic culled
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_cull_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && culled |-> pixels_written == 19'd0) else $error("culled with pixels");
  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid) else $error("result after reset");
endmodule

bind triangle_raster_depth_test_unit trdt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .pixels_written(pixels_written), .culled(culled)
);
